// File: hw/rtl/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine package
// Field widths, command and status codes, and the command and status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_FIND_FIRST = 3'd1,
    CMD_FIND_LAST  = 3'd2,
    CMD_REMOVE     = 3'd3,
    CMD_READ       = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_POS,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDX_M1,
    RA_IDX_P1,
    RA_POS
  } rd_sel_e;

  typedef enum logic {
    WR_SHIFT,
    WR_KEY
  } wr_sel_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_NOT_FOUND,
    RES_FULL,
    RES_INSERT,
    RES_HIT,
    RES_HIT_PREV,
    RES_READ,
    RES_REMOVE
  } res_op_e;

  typedef struct packed {
    logic    latch_in;
    idx_op_e idx_op;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    at_ld;
    logic    key_from_rd;
    logic    cnt_inc;
    logic    cnt_dec;
    res_op_e res_op;
    logic    out_load;
  } sle_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             pos_bad;
    logic             idx_eq_count;
    logic             idx_zero;
    logic             idx_eq_at;
    logic             last_reached;
    logic             ord_ok;
    logic             key_eq;
    logic             out_free;
  } sle_stat_t;

endpackage

// File: hw/rtl/sle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine controller
// Sequences each command over the datapath: scans, shifts through the key
// memory one entry at a time, and hands the result to the output beat.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sle_pkg::sle_stat_t  stat_i,
  output sle_pkg::sle_cmd_t   cmd_o
);
  import sle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_CMP,
    S_SH_RD,
    S_SH_WR,
    S_FF_RD,
    S_FF_CMP,
    S_FL_RD,
    S_FL_CMP,
    S_RM_CAP,
    S_RM_RD,
    S_RM_WR,
    S_RD_CAP,
    S_FIN
  } state_e;

  state_e   state_q, state_d;
  logic     ready_q, ready_d;
  sle_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd.latch_in = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_INSERT: begin
            if (stat_i.full) begin
              cmd.res_op = RES_FULL;
              state_d    = S_FIN;
            end else begin
              cmd.idx_op = IDX_ZERO;
              state_d    = S_INS_RD;
            end
          end
          CMD_FIND_FIRST: begin
            cmd.idx_op = IDX_ZERO;
            state_d    = S_FF_RD;
          end
          CMD_FIND_LAST: begin
            cmd.idx_op = IDX_COUNT;
            state_d    = S_FL_RD;
          end
          CMD_REMOVE: begin
            if (stat_i.pos_bad) begin
              cmd.res_op = RES_NOT_FOUND;
              state_d    = S_FIN;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_POS;
              cmd.idx_op = IDX_POS;
              state_d    = S_RM_CAP;
            end
          end
          CMD_READ: begin
            if (stat_i.pos_bad) begin
              cmd.res_op = RES_NOT_FOUND;
              state_d    = S_FIN;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_POS;
              state_d    = S_RD_CAP;
            end
          end
          default: begin
            cmd.res_op = RES_NOT_FOUND;
            state_d    = S_FIN;
          end
        endcase
      end
      S_INS_RD: begin
        if (stat_i.idx_eq_count) begin
          cmd.at_ld  = 1'b1;
          cmd.idx_op = IDX_COUNT;
          state_d    = S_SH_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_IDX;
          state_d    = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat_i.ord_ok) begin
          cmd.idx_op = IDX_INC;
          state_d    = S_INS_RD;
        end else begin
          cmd.at_ld  = 1'b1;
          cmd.idx_op = IDX_COUNT;
          state_d    = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (stat_i.idx_eq_at) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_KEY;
          cmd.cnt_inc = 1'b1;
          cmd.res_op  = RES_INSERT;
          state_d     = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_IDX_M1;
          state_d    = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.idx_op = IDX_DEC;
        state_d    = S_SH_RD;
      end
      S_FF_RD: begin
        if (stat_i.idx_eq_count) begin
          cmd.res_op = RES_NOT_FOUND;
          state_d    = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_IDX;
          state_d    = S_FF_CMP;
        end
      end
      S_FF_CMP: begin
        if (stat_i.key_eq) begin
          cmd.res_op = RES_HIT;
          state_d    = S_FIN;
        end else begin
          cmd.idx_op = IDX_INC;
          state_d    = S_FF_RD;
        end
      end
      S_FL_RD: begin
        if (stat_i.idx_zero) begin
          cmd.res_op = RES_NOT_FOUND;
          state_d    = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_IDX_M1;
          state_d    = S_FL_CMP;
        end
      end
      S_FL_CMP: begin
        if (stat_i.key_eq) begin
          cmd.res_op = RES_HIT_PREV;
          state_d    = S_FIN;
        end else begin
          cmd.idx_op = IDX_DEC;
          state_d    = S_FL_RD;
        end
      end
      S_RM_CAP: begin
        cmd.key_from_rd = 1'b1;
        state_d         = S_RM_RD;
      end
      S_RM_RD: begin
        if (stat_i.last_reached) begin
          cmd.cnt_dec = 1'b1;
          cmd.res_op  = RES_REMOVE;
          state_d     = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_IDX_P1;
          state_d    = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.idx_op = IDX_INC;
        state_d    = S_RM_RD;
      end
      S_RD_CAP: begin
        cmd.res_op = RES_READ;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    ready_d = (state_d == S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o = ready_q;
  assign cmd_o      = cmd;

endmodule

// File: hw/rtl/sle_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine datapath
// Key memory, count, scan index, key compare, result staging and the
// output beat register.
// ----------------------------------------------------------------------------
module sle_dp #(
  parameter int unsigned DEPTH = sle_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic [sle_pkg::CMD_W-1:0]         command_i,
  input  logic signed [sle_pkg::KEY_W-1:0]  key_i,
  input  logic [sle_pkg::POS_W-1:0]         position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sle_pkg::STAT_W-1:0]        status_o,
  output logic [sle_pkg::POS_W-1:0]         found_position_o,
  output logic                              position_valid_o,
  output logic signed [sle_pkg::KEY_W-1:0]  value_o,
  output logic [sle_pkg::CNT_W-1:0]         entry_count_o,
  input  sle_pkg::sle_cmd_t                 cmd_i,
  output sle_pkg::sle_stat_t                stat_o
);
  import sle_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  logic [KEY_W-1:0]        mem_q [DEPTH];
  logic signed [KEY_W-1:0] rd_q;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [CMD_W-1:0]        cmd_q;
  logic [POS_W-1:0]        pos_q;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           at_q;
  logic                    order_q;

  logic [STAT_W-1:0]       res_status_q, res_status_d;
  logic [POS_W-1:0]        res_pos_q, res_pos_d;
  logic                    res_pvalid_q, res_pvalid_d;
  logic signed [KEY_W-1:0] res_value_q, res_value_d;

  logic                    out_valid_q, out_valid_d;
  logic [STAT_W-1:0]       out_status_q;
  logic [POS_W-1:0]        out_pos_q;
  logic                    out_pvalid_q;
  logic signed [KEY_W-1:0] out_value_q;
  logic [CNT_W-1:0]        out_count_q;

  logic [XW-1:0]           pos_x;
  logic [CW-1:0]           idx_m1, idx_p1, count_m1;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [KEY_W-1:0]        wr_data;

  assign pos_x    = XW'(pos_q);
  assign idx_m1   = idx_q - CW'(1);
  assign idx_p1   = idx_q + CW'(1);
  assign count_m1 = count_q - CW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RA_IDX:    rd_addr = idx_q[AW-1:0];
      RA_IDX_M1: rd_addr = idx_m1[AW-1:0];
      RA_IDX_P1: rd_addr = idx_p1[AW-1:0];
      default:   rd_addr = pos_x[AW-1:0];
    endcase
    case (cmd_i.wr_sel)
      WR_KEY: begin
        wr_addr = at_q[AW-1:0];
        wr_data = key_q;
      end
      default: begin
        wr_addr = idx_q[AW-1:0];
        wr_data = rd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_ZERO:  idx_d = '0;
      IDX_COUNT: idx_d = count_q;
      IDX_POS:   idx_d = pos_x[CW-1:0];
      IDX_INC:   idx_d = idx_p1;
      IDX_DEC:   idx_d = idx_m1;
      default:   idx_d = idx_q;
    endcase

    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_m1;
    end

    key_d = key_q;
    if (cmd_i.latch_in) begin
      key_d = key_i;
    end else if (cmd_i.key_from_rd) begin
      key_d = rd_q;
    end
  end

  always_comb begin
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_pvalid_d = res_pvalid_q;
    res_value_d  = res_value_q;
    case (cmd_i.res_op) inside
      RES_NOT_FOUND, RES_FULL: begin
        res_status_d = (cmd_i.res_op == RES_FULL) ? STATUS_FULL : STATUS_NOT_FOUND;
        res_pos_d    = '0;
        res_pvalid_d = 1'b0;
        res_value_d  = '0;
      end
      RES_INSERT: begin
        res_status_d = STATUS_OK;
        res_pos_d    = POS_W'(at_q);
        res_pvalid_d = 1'b1;
        res_value_d  = key_q;
      end
      RES_HIT: begin
        res_status_d = STATUS_OK;
        res_pos_d    = POS_W'(idx_q);
        res_pvalid_d = 1'b1;
        res_value_d  = key_q;
      end
      RES_HIT_PREV: begin
        res_status_d = STATUS_OK;
        res_pos_d    = POS_W'(idx_m1);
        res_pvalid_d = 1'b1;
        res_value_d  = key_q;
      end
      RES_READ: begin
        res_status_d = STATUS_OK;
        res_pos_d    = pos_q;
        res_pvalid_d = 1'b1;
        res_value_d  = rd_q;
      end
      RES_REMOVE: begin
        res_status_d = STATUS_OK;
        res_value_d  = key_q;
        if (count_m1 == '0) begin
          res_pos_d    = '0;
          res_pvalid_d = 1'b0;
        end else if (pos_x < XW'(count_m1)) begin
          res_pos_d    = pos_q;
          res_pvalid_d = 1'b1;
        end else begin
          res_pos_d    = pos_q - POS_W'(1);
          res_pvalid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = cmd_i.out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      order_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_pvalid_q <= res_pvalid_d;
    res_value_q  <= res_value_d;
    if (cmd_i.latch_in) begin
      cmd_q <= command_i;
      pos_q <= position_i;
    end
    if (cmd_i.at_ld) begin
      at_q <= idx_q;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_pvalid_q <= res_pvalid_q;
      out_value_q  <= res_value_q;
      out_count_q  <= CNT_W'(count_q);
    end
  end

  always_comb begin
    stat_o.cmd          = cmd_q;
    stat_o.full         = (count_q == CW'(DEPTH));
    stat_o.pos_bad      = (pos_x >= XW'(count_q));
    stat_o.idx_eq_count = (idx_q == count_q);
    stat_o.idx_zero     = (idx_q == '0);
    stat_o.idx_eq_at    = (idx_q == at_q);
    stat_o.last_reached = (idx_p1 == count_q);
    stat_o.ord_ok       = order_q ? (rd_q >= key_q) : (rd_q <= key_q);
    stat_o.key_eq       = (rd_q == key_q);
    stat_o.out_free     = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_pos_q;
  assign position_valid_o = out_pvalid_q;
  assign value_o          = out_value_q;
  assign entry_count_o    = out_count_q;

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (count_q < CW'(DEPTH)))
    else $error("insert committed into a full list");

  a_remove_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> (count_q != '0))
    else $error("remove committed on an empty list");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result beat overwritten");
`endif

endmodule

// File: hw/rtl/sorted_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine
// Keeps up to DEPTH signed keys in a sorted array held in one memory, with
// insert, find first, find last, remove at position and read at position.
// ----------------------------------------------------------------------------
// Usage:
//   Command beats arrive on in_valid_i/in_ready_o (command_i, key_i,
//   position_i); one result beat per command leaves on out_valid_o/
//   out_ready_i. cfg_we_i/cfg_wdata_i write order_mode (0 non-decreasing,
//   1 non-increasing); write it only while the engine is idle.
//   One command is worked at a time. The key memory has one read and one
//   write port with registered read data, so each entry scanned takes a
//   read state and a compare state, and each entry shifted a read state
//   and a write state. in_ready_o rises again once the result sits in the
//   output register.
//   Reset empties the list and clears order_mode; no clearing pass is needed.
//   A stalled receiver holds the result in the output register; the next
//   command is still accepted and worked, and waits for the register.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
  parameter int unsigned DEPTH = sle_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sle_pkg::CMD_W-1:0]         command_i,
  input  logic signed [sle_pkg::KEY_W-1:0]  key_i,
  input  logic [sle_pkg::POS_W-1:0]         position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sle_pkg::STAT_W-1:0]        status_o,
  output logic [sle_pkg::POS_W-1:0]         found_position_o,
  output logic                              position_valid_o,
  output logic signed [sle_pkg::KEY_W-1:0]  value_o,
  output logic [sle_pkg::CNT_W-1:0]         entry_count_o
);
  import sle_pkg::*;

  sle_cmd_t  cmd;
  sle_stat_t stat;

  sle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .command_i        (command_i),
    .key_i            (key_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .position_valid_o (position_valid_o),
    .value_o          (value_o),
    .entry_count_o    (entry_count_o),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

endmodule
